>>> hw/rtl/nnc_pkg.sv
// Shared types, widths and constants for the nearest neighbor classifier.
// No dependencies; every other RTL file except nnc_ram imports this package.
package nnc_pkg;

    // Table geometry and feature precision
    localparam int TABLE_DEPTH  = 128;
    localparam int FEATURE_BITS = 8;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);

    // Fixed field widths at the ports
    localparam int SLOT_W  = 7;
    localparam int LABEL_W = 2;
    localparam int CFG_W   = 8;
    localparam int DIST_W  = 18;
    localparam int COUNT_W = 16;
    localparam int FEAT_IN_W = 8;

    // Internal distance width: four squares of FEATURE_BITS differences
    localparam int SQ_W        = 2 * FEATURE_BITS;
    localparam int DIST_FULL_W = SQ_W + 2;
    localparam int DIST_CMP_W  = (DIST_FULL_W > DIST_W) ? DIST_FULL_W : DIST_W;
    localparam int LIM_W       = (CFG_W > IDX_W + 1) ? CFG_W : IDX_W + 1;
    localparam int SLOT_CHK_W  = (SLOT_W > IDX_W + 1) ? SLOT_W : IDX_W + 1;

    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Confusion matrix: three known classes
    localparam int NUM_CLASSES = 3;
    localparam int CELLS       = NUM_CLASSES * NUM_CLASSES;
    localparam int CELL_W      = $clog2(CELLS);

    localparam logic [LABEL_W-1:0] UNKNOWN_CLASS = 2'd3;

    // Stream kinds and register map
    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;
    localparam logic REG_ENTRIES   = 1'b0;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 8'd120;

    typedef logic [3:0][FEATURE_BITS-1:0] t_feat_vec;

    typedef struct packed {
        logic [LABEL_W-1:0] cls;
        t_feat_vec          feat;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                   done;
        logic [IDX_W-1:0]       idx;
        logic [LABEL_W-1:0]     cls;
        logic [DIST_FULL_W-1:0] dist_sq;
    } t_search_res;

    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] cell_idx;
    } t_conf_req;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] count;
    } t_conf_rsp;

    // Clamp the internal distance to the port width
    function automatic logic [DIST_W-1:0] sat_dist(input logic [DIST_FULL_W-1:0] d);
        logic [DIST_CMP_W-1:0] wide;
        wide = DIST_CMP_W'(d);
        if (wide > DIST_CMP_W'(DIST_MAX)) begin
            return DIST_MAX;
        end
        return DIST_W'(wide);
    endfunction

endpackage

>>> hw/rtl/nnc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module nnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/nnc_search.sv
// Table walk: issues one training-table read per cycle, runs a distance
// pipeline (squares, sum, compare) and keeps the running best entry.
// Depends on nnc_pkg.
module nnc_search
    import nnc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_feat_vec        i_sample,
    input  logic [IDX_W-1:0] i_last,
    output logic             o_rd_en,
    output logic [IDX_W-1:0] o_rd_addr,
    input  t_entry           i_rd_data,
    output t_search_res      o_res
);

    // Address issue
    logic             r_issue;
    logic [IDX_W-1:0] r_addr;

    // Pipeline: stage 1 = RAM data, stage 2 = squares, stage 3 = sum
    logic                      r_v1, r_v2, r_v3;
    logic                      r_last1, r_last2, r_last3;
    logic [IDX_W-1:0]          r_idx1, r_idx2, r_idx3;
    logic [LABEL_W-1:0]        r_cls2, r_cls3;
    logic [3:0][SQ_W-1:0]      r_sq2;
    logic [DIST_FULL_W-1:0]    r_dist3;

    // Running best
    logic                      r_done;
    logic [IDX_W-1:0]          r_best_idx;
    logic [LABEL_W-1:0]        r_best_cls;
    logic [DIST_FULL_W-1:0]    r_best_dist;

    logic [3:0][SQ_W-1:0]      sq;
    logic [DIST_FULL_W-1:0]    sum;

    assign o_rd_en   = r_issue;
    assign o_rd_addr = r_addr;

    // Per-feature absolute difference and square
    always_comb begin
        for (int f = 0; f < 4; f++) begin
            logic [FEATURE_BITS-1:0] d;
            d = (i_sample[f] >= i_rd_data.feat[f]) ? i_sample[f] - i_rd_data.feat[f]
                                                   : i_rd_data.feat[f] - i_sample[f];
            sq[f] = SQ_W'(d * d);
        end
    end

    assign sum = DIST_FULL_W'(r_sq2[0]) + DIST_FULL_W'(r_sq2[1])
               + DIST_FULL_W'(r_sq2[2]) + DIST_FULL_W'(r_sq2[3]);

    // Control: issue counter and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            if (i_start) begin
                r_issue <= 1'b1;
            end else if (r_issue && r_addr == i_last) begin
                r_issue <= 1'b0;
            end
            r_v1   <= r_issue;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3 && r_last3;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_addr <= '0;
        end else if (r_issue) begin
            r_addr <= r_addr + 1'b1;
        end
        r_idx1  <= r_addr;
        r_last1 <= (r_addr == i_last);
        r_idx2  <= r_idx1;
        r_last2 <= r_last1;
        r_cls2  <= i_rd_data.cls;
        r_sq2   <= sq;
        r_idx3  <= r_idx2;
        r_last3 <= r_last2;
        r_cls3  <= r_cls2;
        r_dist3 <= sum;
        // entry 0 seeds the best; later ones replace it only when strictly closer
        if (r_v3 && (r_idx3 == '0 || r_dist3 < r_best_dist)) begin
            r_best_idx  <= r_idx3;
            r_best_cls  <= r_cls3;
            r_best_dist <= r_dist3;
        end
    end

    assign o_res = '{done: r_done, idx: r_best_idx, cls: r_best_cls, dist_sq: r_best_dist};

endmodule

>>> hw/rtl/nnc_confusion.sv
// Confusion matrix: nine saturating counters in a small RAM, updated by a
// read-increment-write sequence. Per-cell valid bits make reset read as zero.
// Depends on nnc_pkg and nnc_ram.
module nnc_confusion
    import nnc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_conf_req i_req,
    output t_conf_rsp o_rsp
);

    logic [CELLS-1:0]   r_valid;
    logic               r_pend;
    logic               r_rd_valid;
    logic [CELL_W-1:0]  r_cell;
    logic [COUNT_W-1:0] rd_data;
    logic [COUNT_W-1:0] cur;
    logic [COUNT_W-1:0] nxt;

    nnc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (CELLS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (r_pend),
        .i_waddr (r_cell),
        .i_wdata (nxt),
        .i_re    (i_req.valid),
        .i_raddr (i_req.cell_idx),
        .o_rdata (rd_data)
    );

    // Increment with saturation; an unwritten cell counts from zero
    assign cur = r_rd_valid ? rd_data : '0;
    assign nxt = (cur == COUNT_MAX) ? cur : cur + 1'b1;

    // Requests come one at a time, so the write-back never overlaps a read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= i_req.valid;
            if (r_pend) begin
                r_valid[r_cell] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_cell     <= i_req.cell_idx;
            r_rd_valid <= r_valid[i_req.cell_idx];
        end
    end

    assign o_rsp = '{done: r_pend, count: nxt};

endmodule

>>> hw/rtl/nearest_neighbor_classifier_unit.sv
// Top level of the one-nearest-neighbor classifier: stream ports, APB
// register, training table RAM, sequencer and result register.
// Depends on nnc_pkg, nnc_ram, nnc_search and nnc_confusion.
//
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------------
// s_axis   | in        | tvalid/tready          | tdata 48b, tuser = kind
// m_axis   | out       | tvalid/tready          | tdata 48b, tuser = bad_label
// apb      | in        | psel/penable, pready=1 | entries_in_use at address 0
//
// Load request: the result register is loaded in the emit state once the output is free.
// Classify request: the table RAM's single read port delivers one entry per cycle for
// N = entries_in_use clamped to 1..TABLE_DEPTH, then come a 4-stage distance pipeline and
// a counter read-modify-write (skipped with an unknown label) before the result register.
// The next request is accepted once the result register is loaded.
// One request is in work at a time; the next is accepted while a result waits.
// Reset is synchronous; counters read as zero right after it, no clearing pass.
module nearest_neighbor_classifier_unit
    import nnc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [6:0] entry_index, [14:7] feature_a, [22:15] feature_b,
    // [30:23] feature_c, [38:31] feature_d, [40:39] label, [47:41] zero
    input  logic [47:0] s_axis_tdata,
    // [0] kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] predicted_class, [8:2] nearest_slot, [26:9] best_distance_sq,
    // [42:27] cell_count, [47:43] zero
    output logic [47:0] m_axis_tdata,
    // [0] bad_label
    output logic        m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_COUNT  = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]          r_state;
    logic [CFG_W-1:0]    r_entries;
    t_feat_vec           r_sample;
    logic [LABEL_W-1:0]  r_label;
    logic [IDX_W-1:0]    r_last;
    logic                r_start;

    // Pending result
    logic [LABEL_W-1:0]  r_res_pred;
    logic [SLOT_W-1:0]   r_res_slot;
    logic [DIST_W-1:0]   r_res_dist;
    logic [COUNT_W-1:0]  r_res_count;
    logic                r_res_bad;

    // Output register
    logic                r_out_valid;
    logic [47:0]         r_out_data;
    logic                r_out_bad;

    // Request fields
    logic [SLOT_W-1:0]   in_slot;
    t_feat_vec           in_feat;
    logic [LABEL_W-1:0]  in_label;
    logic                in_fire;
    logic                load_we;
    logic [LIM_W-1:0]    n_lim;
    logic [IDX_W-1:0]    n_last;

    logic                tbl_re;
    logic [IDX_W-1:0]    tbl_raddr;
    t_entry              tbl_rdata;
    t_search_res         srch_res;
    t_conf_req           conf_req;
    t_conf_rsp           conf_rsp;
    logic                out_free;
    logic                srch_bad;
    logic [CELL_W-1:0]   cell_idx;

    assign in_slot    = s_axis_tdata[6:0];
    assign in_feat[0] = FEATURE_BITS'(s_axis_tdata[14:7]);
    assign in_feat[1] = FEATURE_BITS'(s_axis_tdata[22:15]);
    assign in_feat[2] = FEATURE_BITS'(s_axis_tdata[30:23]);
    assign in_feat[3] = FEATURE_BITS'(s_axis_tdata[38:31]);
    assign in_label   = s_axis_tdata[40:39];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign load_we       = in_fire && (s_axis_tuser == KIND_LOAD)
                        && (SLOT_CHK_W'(in_slot) < SLOT_CHK_W'(TABLE_DEPTH));

    // Search length: zero acts as one, too large saturates at the table depth
    always_comb begin
        if (r_entries == '0) begin
            n_lim = LIM_W'(1);
        end else if (LIM_W'(r_entries) > LIM_W'(TABLE_DEPTH)) begin
            n_lim = LIM_W'(TABLE_DEPTH);
        end else begin
            n_lim = LIM_W'(r_entries);
        end
        n_last = IDX_W'(n_lim - 1'b1);
    end

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRIES) ? 32'(r_entries) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRIES) begin
            r_entries <= pwdata[CFG_W-1:0];
        end
    end

    // Training table
    nnc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (IDX_W'(in_slot)),
        .i_wdata ({in_label, in_feat}),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    nnc_search u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_sample  (r_sample),
        .i_last    (r_last),
        .o_rd_en   (tbl_re),
        .o_rd_addr (tbl_raddr),
        .i_rd_data (tbl_rdata),
        .o_res     (srch_res)
    );

    // Cell index = true * 3 + predicted
    assign srch_bad = (r_label == UNKNOWN_CLASS) || (srch_res.cls == UNKNOWN_CLASS);
    assign cell_idx = CELL_W'({r_label, 1'b0}) + CELL_W'(r_label) + CELL_W'(srch_res.cls);
    assign conf_req = '{valid: (r_state == ST_SEARCH) && srch_res.done && !srch_bad,
                        cell_idx: cell_idx};

    nnc_confusion u_confusion (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (conf_req),
        .o_rsp   (conf_rsp)
    );

    assign out_free = !r_out_valid || m_axis_tready;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= in_fire && (s_axis_tuser == KIND_CLASSIFY);
            // output register: loaded from the pending result, cleared once taken
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (s_axis_tuser == KIND_CLASSIFY) begin
                            r_state <= ST_SEARCH;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (srch_res.done) begin
                        r_state <= srch_bad ? ST_EMIT : ST_COUNT;
                    end
                end
                ST_COUNT: begin
                    if (conf_rsp.done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Request capture and result assembly
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample    <= in_feat;
            r_label     <= in_label;
            r_last      <= n_last;
            r_res_pred  <= '0;
            r_res_slot  <= '0;
            r_res_dist  <= '0;
            r_res_count <= '0;
            r_res_bad   <= 1'b0;
        end
        if (r_state == ST_SEARCH && srch_res.done) begin
            r_res_pred <= srch_res.cls;
            r_res_slot <= SLOT_W'(srch_res.idx);
            r_res_dist <= sat_dist(srch_res.dist_sq);
            r_res_bad  <= srch_bad;
        end
        if (r_state == ST_COUNT && conf_rsp.done) begin
            r_res_count <= conf_rsp.count;
        end
        if (r_state == ST_EMIT && out_free) begin
            r_out_data <= {5'b0, r_res_count, r_res_dist, r_res_slot, r_res_pred};
            r_out_bad  <= r_res_bad;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_bad;

    // The search finishes only while the sequencer waits for it
    a_search_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_res.done |-> r_state == ST_SEARCH)
        else $error("search finished outside the search state");

    // A counter update completes only while the sequencer waits for it
    a_count_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conf_rsp.done |-> r_state == ST_COUNT)
        else $error("counter update outside the count state");

    // A result held for a stalled output stays pending
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_out_valid && !m_axis_tready) |=> r_state == ST_EMIT)
        else $error("pending result dropped while output stalled");

    // A flagged label never carries a count
    a_bad_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_res_bad) |-> r_res_count == '0)
        else $error("count reported with an unknown label");

endmodule

>>> test/nearest_neighbor_classifier_unit_tb.sv
// Self-checking testbench for nearest_neighbor_classifier_unit: stream requests in,
// responses checked field by field against an in-bench nearest neighbor predictor.
// Depends on nnc_pkg and the classifier RTL only.
module nearest_neighbor_classifier_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nnc_pkg::*;

    localparam int REG_STRIDE = 4;
    localparam int REG_SPARE  = 1;
    localparam int FEAT_TOP   = (1 << FEAT_IN_W) - 1;
    localparam int SHOW_MAX   = 40;
    // entries_in_use per random phase; slot 5 is replaced by a random value
    localparam logic [7:0][CFG_W-1:0] PHASE_CFG =
        {8'd3, 8'd64, 8'd0, 8'd16, 8'd200, 8'd37, 8'd128, 8'd1};

    typedef struct packed {
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        t_feat_vec          feat;
        logic [LABEL_W-1:0] label;
    } t_nn_req;

    typedef struct packed {
        logic [LABEL_W-1:0] pred;
        logic [SLOT_W-1:0]  slot;
        logic [DIST_W-1:0]  dsq;
        logic [COUNT_W-1:0] count;
        logic               bad;
    } t_nn_rsp;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: training table, confusion counters, register copy
    t_feat_vec          train_feat [TABLE_DEPTH];
    logic [LABEL_W-1:0] train_cls  [TABLE_DEPTH];
    logic [COUNT_W-1:0] conf_cnt   [CELLS];
    logic [CFG_W-1:0]   entries_cfg = ENTRIES_RESET;

    t_nn_req queued_requests [$];
    t_nn_rsp awaited_rsp [$];

    int unsigned mismatches = 0;
    int unsigned tx_gap     = 0;
    int unsigned rx_wait    = 0;
    int unsigned rx_hold    = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;

    nearest_neighbor_classifier_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int c = 0; c < CELLS; c++) begin
            conf_cnt[c] = '0;
        end
    end

    // Entries searched per classify request after clamping
    function automatic int unsigned search_limit();
        int unsigned lim;
        lim = entries_cfg;
        if (lim < 1) lim = 1;
        if (lim > TABLE_DEPTH) lim = TABLE_DEPTH;
        return lim;
    endfunction

    // Expected response; updates table and counters like the block does
    function automatic t_nn_rsp predict_response(input t_nn_req r);
        t_nn_rsp     rsp;
        int unsigned lim, best, dsq, best_dsq, cell_idx, i, f;
        int          diff;
        rsp = '0;
        if (r.kind == KIND_LOAD) begin
            train_feat[r.slot] = r.feat;
            train_cls[r.slot]  = r.label;
            return rsp;
        end
        lim      = search_limit();
        best     = 0;
        best_dsq = 32'hFFFF_FFFF;
        // first strict minimum wins
        for (i = 0; i < lim; i++) begin
            dsq = 0;
            for (f = 0; f < 4; f++) begin
                diff = int'(r.feat[f]) - int'(train_feat[i][f]);
                dsq += diff * diff;
            end
            if (dsq < best_dsq) begin
                best_dsq = dsq;
                best     = i;
            end
        end
        rsp.pred = train_cls[best];
        rsp.slot = SLOT_W'(best);
        rsp.dsq  = (best_dsq > DIST_MAX) ? DIST_MAX : DIST_W'(best_dsq);
        if (r.label == UNKNOWN_CLASS || rsp.pred == UNKNOWN_CLASS) begin
            rsp.bad = 1'b1;
        end else begin
            cell_idx = r.label * NUM_CLASSES + rsp.pred;
            if (conf_cnt[cell_idx] != COUNT_MAX) conf_cnt[cell_idx]++;
            rsp.count = conf_cnt[cell_idx];
        end
        return rsp;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned roll;
        if (!enabled) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_feat_vec random_features();
        t_feat_vec   fv;
        int unsigned roll, f;
        for (f = 0; f < 4; f++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) fv[f] = '0;
            else if (roll == 1) fv[f] = '1;
            else fv[f] = FEAT_IN_W'($urandom());
        end
        return fv;
    endfunction

    // Sample close to a stored entry so that predictions spread over the table
    function automatic t_feat_vec near_sample(input int unsigned base);
        t_feat_vec   fv;
        int          v;
        int unsigned f;
        for (f = 0; f < 4; f++) begin
            v = int'(train_feat[base][f]) + int'($urandom_range(0, 12)) - 6;
            if (v < 0) v = 0;
            if (v > FEAT_TOP) v = FEAT_TOP;
            fv[f] = FEAT_IN_W'(v);
        end
        return fv;
    endfunction

    task automatic queue_request(input logic kind, input int unsigned slot,
                                 input t_feat_vec feat, input logic [LABEL_W-1:0] label);
        t_nn_req r;
        r.kind  = kind;
        r.slot  = SLOT_W'(slot);
        r.feat  = feat;
        r.label = label;
        queued_requests.push_back(r);
    endtask

    task automatic note_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
        mismatches++;
        if (mismatches <= SHOW_MAX) begin
            $display("[%0t] %s: got %0d, expected %0d", $realtime, field, got, want);
        end
    endtask

    // Wait until every request is taken and every response has come back
    task automatic drain();
        while (queued_requests.size() != 0 || awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // APB write: setup then access; register takes the value at the access edge
    task automatic write_reg(input int unsigned idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * REG_STRIDE);
        pwdata  <= {24'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ENTRIES) entries_cfg = value;
    endtask

    // Loads and classify requests mixed, classify samples mostly near stored entries
    task automatic random_phase(input int unsigned items);
        int unsigned        k, lim, slot, roll;
        t_feat_vec          fv;
        logic [LABEL_W-1:0] lab;
        lim = search_limit();
        for (k = 0; k < items; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                if ($urandom_range(0, 3) != 0) slot = $urandom_range(0, lim - 1);
                else slot = $urandom_range(0, TABLE_DEPTH - 1);
                // copies of another entry create distance ties
                if (roll < 5) fv = train_feat[$urandom_range(0, lim - 1)];
                else fv = random_features();
                if ($urandom_range(0, 19) == 0) lab = UNKNOWN_CLASS;
                else lab = LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
                queue_request(KIND_LOAD, slot, fv, lab);
            end else begin
                if (roll < 75) fv = near_sample($urandom_range(0, lim - 1));
                else fv = random_features();
                if ($urandom_range(0, 9) == 0) lab = UNKNOWN_CLASS;
                else lab = LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
                queue_request(KIND_CLASSIFY, $urandom_range(0, TABLE_DEPTH - 1), fv, lab);
            end
        end
    endtask

    // Request driver: presents the head of the queue, holds it while stalled
    always @(posedge i_clk) begin : request_driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_rsp.push_back(predict_response(queued_requests.pop_front()));
                tx_gap = pick_gap(tx_gaps_on);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'b0, queued_requests[0].label,
                                      queued_requests[0].feat, queued_requests[0].slot};
                    s_axis_tuser  <= queued_requests[0].kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: compares against the oldest prediction, stalls at random
    always @(posedge i_clk) begin : response_monitor
        t_nn_rsp got;
        t_nn_rsp want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.pred  = m_axis_tdata[1:0];
                got.slot  = m_axis_tdata[8:2];
                got.dsq   = m_axis_tdata[26:9];
                got.count = m_axis_tdata[42:27];
                got.bad   = m_axis_tuser;
                if (awaited_rsp.size() == 0) begin
                    note_mismatch("response with no request pending", m_axis_tdata, 0);
                end else begin
                    want = awaited_rsp.pop_front();
                    if (got.pred != want.pred)
                        note_mismatch("predicted_class", got.pred, want.pred);
                    if (got.slot != want.slot)
                        note_mismatch("nearest_slot", got.slot, want.slot);
                    if (got.dsq != want.dsq)
                        note_mismatch("best_distance_sq", got.dsq, want.dsq);
                    if (got.count != want.count)
                        note_mismatch("cell_count", got.count, want.count);
                    if (got.bad != want.bad)
                        note_mismatch("bad_label", got.bad, want.bad);
                end
                rx_wait = pick_gap(rx_gaps_on);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus sequence
    initial begin : stimulus
        t_feat_vec          fv, twin, odd_entry;
        logic [LABEL_W-1:0] lab;
        int unsigned        i, p;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole table before any search; a few entries are pinned
        twin      = random_features();
        odd_entry = random_features();
        for (i = 0; i < TABLE_DEPTH; i++) begin
            fv  = random_features();
            lab = LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
            if (i == 0) begin
                fv  = '0;
                lab = '0;
            end
            if (i == 5) begin
                fv  = odd_entry;
                lab = UNKNOWN_CLASS;
            end
            if (i == 10 || i == 11) fv = twin;
            if (i == TABLE_DEPTH - 1) begin
                fv  = '1;
                lab = LABEL_W'(NUM_CLASSES - 1);
            end
            queue_request(KIND_LOAD, i, fv, lab);
        end

        // Directed searches at the reset setting
        queue_request(KIND_CLASSIFY, 0, '0, LABEL_W'(0));
        queue_request(KIND_CLASSIFY, TABLE_DEPTH - 1, '1, LABEL_W'(1));
        queue_request(KIND_CLASSIFY, 11, twin, LABEL_W'(2));
        queue_request(KIND_CLASSIFY, 5, odd_entry, LABEL_W'(0));
        queue_request(KIND_CLASSIFY, 0, random_features(), UNKNOWN_CLASS);
        queue_request(KIND_CLASSIFY, 0, {8'hFF, 8'h00, 8'hFF, 8'h00}, LABEL_W'(1));
        drain();

        // Zero entry count searches entry 0 only; largest possible distance
        write_reg(REG_ENTRIES, 8'd0);
        queue_request(KIND_CLASSIFY, 0, '1, LABEL_W'(0));
        queue_request(KIND_CLASSIFY, 0, '0, LABEL_W'(1));
        drain();

        // Oversized count clamps to the full table
        write_reg(REG_ENTRIES, 8'd255);
        queue_request(KIND_CLASSIFY, 0, '1, LABEL_W'(2));
        drain();

        // Write to an unmapped register must leave the count alone
        write_reg(REG_SPARE, 8'd2);
        queue_request(KIND_CLASSIFY, 0, '1, LABEL_W'(2));
        drain();

        // Random phases over several settings and idling styles
        for (p = 0; p < 8; p++) begin
            if (p == 5) write_reg(REG_ENTRIES, CFG_W'($urandom_range(2, TABLE_DEPTH - 1)));
            else write_reg(REG_ENTRIES, PHASE_CFG[p]);
            tx_gaps_on = (p % 3 != 2);
            rx_gaps_on = (p % 4 != 1);
            if (p == 4) begin
                // long receiver hold-off while the sender keeps offering
                tx_gaps_on = 1'b0;
                rx_hold    = 500;
            end
            random_phase(90);
            drain();
        end

        repeat (150) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Run limit
    initial begin : watchdog
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
